### rtl/rmcd_pkg.sv
// Shared types and codes of the movi chunk demultiplexer.
`timescale 1ns / 1ps

package rmcd_pkg;

    // Operation codes of an input request
    localparam logic [1:0] OP_DATA   = 2'd0;
    localparam logic [1:0] OP_ENDED  = 2'd1;
    localparam logic [1:0] OP_REWIND = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Result kinds
    localparam logic [2:0] KIND_VIDEO       = 3'd0;
    localparam logic [2:0] KIND_AUDIO       = 3'd1;
    localparam logic [2:0] KIND_EMPTY_VIDEO = 3'd2;
    localparam logic [2:0] KIND_EMPTY_AUDIO = 3'd3;
    localparam logic [2:0] KIND_END         = 3'd4;
    localparam logic [2:0] KIND_TRUNCATED   = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] CFG_MOVI_SIZE    = 3'd0;
    localparam logic [2:0] CFG_VIDEO_STREAM = 3'd1;
    localparam logic [2:0] CFG_AUDIO_STREAM = 3'd2;
    localparam logic [2:0] CFG_VIDEO_ENABLE = 3'd3;
    localparam logic [2:0] CFG_AUDIO_ENABLE = 3'd4;

    // Little-endian fourcc values and tag characters
    localparam logic [31:0] TAG_LIST = 32'h5453494C;
    localparam logic [31:0] TAG_JUNK = 32'h4B4E554A;
    localparam logic [7:0]  CHR_0    = 8'h30;
    localparam logic [7:0]  CHR_9    = 8'h39;
    localparam logic [7:0]  CHR_D    = 8'h64;
    localparam logic [7:0]  CHR_C    = 8'h63;
    localparam logic [7:0]  CHR_B    = 8'h62;
    localparam logic [7:0]  CHR_W    = 8'h77;
    localparam logic [3:0]  DEC_BASE = 4'd10;

    // Largest value of the saturating byte position
    localparam logic [32:0] POS_MAX = {33{1'b1}};

    // Decision on a completed chunk header
    typedef struct packed {
        logic is_list;   // descend: skip the list type
        logic skip;      // junk, unknown or unselected chunk
        logic audio_sel; // selected audio chunk (else selected video)
    } t_tag_info;

endpackage

### rtl/rmcd_tag_sort.sv
// Fourcc classifier: list, skip, or selected video / audio chunk.
`timescale 1ns / 1ps

module rmcd_tag_sort (
    input  logic [31:0]        i_tag,
    input  logic [6:0]         i_video_stream,
    input  logic [6:0]         i_audio_stream,
    input  logic               i_video_enable,
    input  logic               i_audio_enable,
    output rmcd_pkg::t_tag_info o_info
);

    logic [7:0] w_c0, w_c1, w_c2, w_c3;
    logic       w_digits;
    logic [3:0] w_tens, w_ones;
    logic [6:0] w_num;
    logic       w_vid_tag, w_aud_tag, w_vid_sel, w_aud_sel;

    assign w_c0 = i_tag[7:0];
    assign w_c1 = i_tag[15:8];
    assign w_c2 = i_tag[23:16];
    assign w_c3 = i_tag[31:24];

    // Two leading decimal digits give the stream number
    assign w_digits = (w_c0 >= rmcd_pkg::CHR_0) && (w_c0 <= rmcd_pkg::CHR_9) &&
                      (w_c1 >= rmcd_pkg::CHR_0) && (w_c1 <= rmcd_pkg::CHR_9);
    assign w_tens   = w_c0[3:0];
    assign w_ones   = w_c1[3:0];
    assign w_num    = 7'(w_tens) * 7'(rmcd_pkg::DEC_BASE) + 7'(w_ones);

    // "dc"/"db" is video, "wb" is audio
    assign w_vid_tag = w_digits && (w_c2 == rmcd_pkg::CHR_D) &&
                       ((w_c3 == rmcd_pkg::CHR_C) || (w_c3 == rmcd_pkg::CHR_B));
    assign w_aud_tag = w_digits && (w_c2 == rmcd_pkg::CHR_W) && (w_c3 == rmcd_pkg::CHR_B);

    assign w_vid_sel = w_vid_tag && i_video_enable && (w_num == i_video_stream);
    assign w_aud_sel = w_aud_tag && i_audio_enable && (w_num == i_audio_stream);

    assign o_info.is_list   = (i_tag == rmcd_pkg::TAG_LIST);
    assign o_info.skip      = (i_tag == rmcd_pkg::TAG_JUNK) || (!w_vid_sel && !w_aud_sel);
    assign o_info.audio_sel = w_aud_sel;

endmodule

### rtl/riff_movi_chunk_demux.sv
// Top level of the AVI movi list chunk demultiplexer.
`timescale 1ns / 1ps

// Takes one movi content request per cycle (data byte, input ended, rewind)
// and gives at most one result per request: payload bytes of the selected
// video and audio streams, empty-chunk markers, end of movi and a truncation
// error. A request is captured in an input register and parsed in a single
// pass into the result register, so the sustained rate is one request per
// clock; the input side keeps accepting while the result register is free
// or drained in the same cycle. A result reaches the output as its request
// moves from the input register into the result register. No clearing pass
// runs after reset. Configuration is written through its own port, always
// ready; the user must do so only while no request is in flight (unchecked).
module riff_movi_chunk_demux (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input requests
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_data_byte,
    // results
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [31:0] o_chunk_size,
    output logic [31:0] o_frame_num,
    output logic        o_chunk_last,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PAYLOAD,
        PH_PAD,
        PH_DONE
    } t_phase;

    // configuration registers
    logic [31:0] r_movi_size;
    logic [6:0]  r_video_stream, r_audio_stream;
    logic        r_video_enable, r_audio_enable;

    // input register
    logic        r_in_vld;
    logic [1:0]  r_op;
    logic [7:0]  r_byte;

    // parser state
    t_phase      r_phase, n_phase;
    logic [55:0] r_hdr, n_hdr;
    logic [2:0]  r_hdr_cnt, n_hdr_cnt;
    logic [31:0] r_bytes_left, n_bytes_left;
    logic        r_pad, n_pad;
    logic        r_cur_audio, n_cur_audio;
    logic [31:0] r_cur_size, n_cur_size;
    logic [31:0] r_cur_frame, n_cur_frame;
    logic [32:0] r_pos, n_pos;
    logic [31:0] r_frame_cnt, n_frame_cnt;

    // result register
    logic        r_out_vld;
    logic [2:0]  r_kind, n_kind;
    logic [7:0]  r_pay, n_pay;
    logic [31:0] r_size, n_size;
    logic [31:0] r_frame, n_frame;
    logic        r_last, n_last;
    logic        w_emit;

    logic        w_adv;
    logic [31:0] w_hdr_size;
    logic [31:0] w_left_dec;
    rmcd_pkg::t_tag_info w_info;

    // Handshakes: input register drains into result register
    assign w_adv       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || w_adv;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid    = r_out_vld;
    assign o_kind         = r_kind;
    assign o_payload_byte = r_pay;
    assign o_chunk_size   = r_size;
    assign o_frame_num    = r_frame;
    assign o_chunk_last   = r_last;

    // Header decode: fourcc in the low word, size top byte is the current byte
    assign w_hdr_size = {r_byte, r_hdr[55:32]};
    assign w_left_dec = r_bytes_left - 32'd1;

    rmcd_tag_sort u_tag_sort (
        .i_tag          (r_hdr[31:0]),
        .i_video_stream (r_video_stream),
        .i_audio_stream (r_audio_stream),
        .i_video_enable (r_video_enable),
        .i_audio_enable (r_audio_enable),
        .o_info         (w_info)
    );

    // Single-pass parser step for the request held in the input register
    always_comb begin
        n_phase      = r_phase;
        n_hdr        = r_hdr;
        n_hdr_cnt    = r_hdr_cnt;
        n_bytes_left = r_bytes_left;
        n_pad        = r_pad;
        n_cur_audio  = r_cur_audio;
        n_cur_size   = r_cur_size;
        n_cur_frame  = r_cur_frame;
        n_pos        = r_pos;
        n_frame_cnt  = r_frame_cnt;
        w_emit       = 1'b0;
        n_kind       = rmcd_pkg::KIND_END;
        n_pay        = 8'd0;
        n_size       = 32'd0;
        n_frame      = 32'd0;
        n_last       = 1'b0;

        priority if (r_op == rmcd_pkg::OP_NONE) begin
            // ignored
        end else if (r_op == rmcd_pkg::OP_REWIND) begin
            n_phase      = PH_HEADER;
            n_hdr_cnt    = 3'd0;
            n_bytes_left = 32'd0;
            n_pad        = 1'b0;
            n_cur_audio  = 1'b0;
            n_cur_size   = 32'd0;
            n_cur_frame  = 32'd0;
            n_pos        = 33'd0;
            n_frame_cnt  = 32'd0;
        end else if (r_phase == PH_DONE) begin
            // finished: only input ended answers
            w_emit = (r_op == rmcd_pkg::OP_ENDED);
        end else if (r_phase == PH_HEADER && r_hdr_cnt == 3'd0 &&
                     r_pos >= {1'b0, r_movi_size}) begin
            // end of movi at a header boundary, byte not consumed
            n_phase = PH_DONE;
            w_emit  = 1'b1;
        end else if (r_op == rmcd_pkg::OP_ENDED) begin
            n_phase = PH_DONE;
            w_emit  = 1'b1;
            if (r_phase == PH_PAYLOAD) begin
                n_kind  = rmcd_pkg::KIND_TRUNCATED;
                n_size  = r_cur_size;
                n_frame = r_cur_frame;
            end
        end else begin
            if (r_pos != rmcd_pkg::POS_MAX) begin
                n_pos = r_pos + 33'd1;
            end
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_hdr_cnt != 3'd7) begin
                        n_hdr     = {r_byte, r_hdr[55:8]};
                        n_hdr_cnt = r_hdr_cnt + 3'd1;
                    end else begin
                        n_hdr_cnt = 3'd0;
                        if (w_info.is_list) begin
                            n_bytes_left = 32'd4;
                            n_pad        = 1'b0;
                            n_phase      = PH_SKIP;
                        end else if (w_info.skip) begin
                            // zero size has no pad, so back to header
                            n_bytes_left = w_hdr_size;
                            n_pad        = w_hdr_size[0];
                            n_phase      = (w_hdr_size != 32'd0) ? PH_SKIP : PH_HEADER;
                        end else begin
                            n_cur_audio = w_info.audio_sel;
                            n_cur_size  = w_hdr_size;
                            n_cur_frame = w_info.audio_sel ? 32'd0 : r_frame_cnt;
                            if (!w_info.audio_sel) begin
                                n_frame_cnt = r_frame_cnt + 32'd1;
                            end
                            if (w_hdr_size == 32'd0) begin
                                // empty chunk marker
                                n_phase = PH_HEADER;
                                w_emit  = 1'b1;
                                n_kind  = w_info.audio_sel ? rmcd_pkg::KIND_EMPTY_AUDIO
                                                           : rmcd_pkg::KIND_EMPTY_VIDEO;
                                n_frame = w_info.audio_sel ? 32'd0 : r_frame_cnt;
                                n_last  = 1'b1;
                            end else begin
                                n_bytes_left = w_hdr_size;
                                n_pad        = w_hdr_size[0];
                                n_phase      = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_SKIP: begin
                    n_bytes_left = w_left_dec;
                    if (w_left_dec == 32'd0) begin
                        n_phase = r_pad ? PH_PAD : PH_HEADER;
                    end
                end
                PH_PAD: begin
                    n_pad   = 1'b0;
                    n_phase = PH_HEADER;
                end
                PH_PAYLOAD: begin
                    n_bytes_left = w_left_dec;
                    if (w_left_dec == 32'd0) begin
                        n_phase = r_pad ? PH_PAD : PH_HEADER;
                    end
                    w_emit  = 1'b1;
                    n_kind  = r_cur_audio ? rmcd_pkg::KIND_AUDIO : rmcd_pkg::KIND_VIDEO;
                    n_pay   = r_byte;
                    n_size  = r_cur_size;
                    n_frame = r_cur_frame;
                    n_last  = (w_left_dec == 32'd0);
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_movi_size    <= 32'd0;
            r_video_stream <= 7'd0;
            r_audio_stream <= 7'd1;
            r_video_enable <= 1'b1;
            r_audio_enable <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rmcd_pkg::CFG_MOVI_SIZE:    r_movi_size    <= i_cfg_data;
                rmcd_pkg::CFG_VIDEO_STREAM: r_video_stream <= i_cfg_data[6:0];
                rmcd_pkg::CFG_AUDIO_STREAM: r_audio_stream <= i_cfg_data[6:0];
                rmcd_pkg::CFG_VIDEO_ENABLE: r_video_enable <= i_cfg_data[0];
                rmcd_pkg::CFG_AUDIO_ENABLE: r_audio_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_op   <= i_operation;
            r_byte <= i_data_byte;
        end
    end

    // Parser state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_hdr_cnt    <= 3'd0;
            r_bytes_left <= 32'd0;
            r_pad        <= 1'b0;
            r_cur_audio  <= 1'b0;
            r_cur_size   <= 32'd0;
            r_cur_frame  <= 32'd0;
            r_pos        <= 33'd0;
            r_frame_cnt  <= 32'd0;
            r_out_vld    <= 1'b0;
        end else if (w_adv) begin
            r_phase      <= n_phase;
            r_hdr_cnt    <= n_hdr_cnt;
            r_bytes_left <= n_bytes_left;
            r_pad        <= n_pad;
            r_cur_audio  <= n_cur_audio;
            r_cur_size   <= n_cur_size;
            r_cur_frame  <= n_cur_frame;
            r_pos        <= n_pos;
            r_frame_cnt  <= n_frame_cnt;
            r_out_vld    <= w_emit;
        end else if (i_out_ready) begin
            r_out_vld    <= 1'b0;
        end
        if (w_adv) begin
            r_hdr <= n_hdr;
        end
        if (w_adv && w_emit) begin
            r_kind  <= n_kind;
            r_pay   <= n_pay;
            r_size  <= n_size;
            r_frame <= n_frame;
            r_last  <= n_last;
        end
    end

`ifndef SYNTH
    // a payload or skip phase always has bytes still to go
    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD || r_phase == PH_SKIP) |-> (r_bytes_left != 32'd0))
        else $error("payload or skip phase with no bytes left");

    // a partial header is left only while collecting a header or once finished
    a_hdr_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hdr_cnt != 3'd0) |-> (r_phase == PH_HEADER || r_phase == PH_DONE))
        else $error("partial header outside header phase");

    // rewind returns position and frame counter to zero
    a_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_op == rmcd_pkg::OP_REWIND) |=> (r_pos == 33'd0 && r_frame_cnt == 32'd0))
        else $error("rewind did not clear position");

    // a truncation error is never flagged as a chunk's last byte
    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_emit && n_kind == rmcd_pkg::KIND_TRUNCATED) |=> (r_out_vld && !r_last))
        else $error("truncation result marked last");
`endif

endmodule

### bench/tb_riff_movi_chunk_demux.sv
// Self-checking bench for the movi chunk demultiplexer against a bit-true predictor.
`timescale 1ns / 1ps

module tb_riff_movi_chunk_demux;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int REQ_TARGET     = 1250;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_CYCLES     = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [2:0] {
        PS_HEADER, PS_SKIP, PS_PAYLOAD, PS_PAD, PS_DONE
    } t_parse_state;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
    } t_movi_req;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  pbyte;
        logic [31:0] csize;
        logic [31:0] frame;
        logic        last;
    } t_chunk_res;

    // Clock, reset and DUT ports
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [1:0]  req_op    = rmcd_pkg::OP_DATA;
    logic [7:0]  req_byte  = 8'h00;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [2:0]  res_kind;
    logic [7:0]  res_byte;
    logic [31:0] res_size;
    logic [31:0] res_frame;
    logic        res_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = rmcd_pkg::CFG_MOVI_SIZE;
    logic [31:0] cfg_data  = 32'h0;

    // Predictor copy of the registers (reset values)
    logic [31:0] movi_lim = 32'h0;
    logic [6:0]  vid_num  = 7'd0;
    logic [6:0]  aud_num  = 7'd1;
    logic        vid_en   = 1'b1;
    logic        aud_en   = 1'b0;

    // Predictor copy of the parser state
    logic [55:0]  hdr_shift;
    logic [2:0]   hdr_cnt;
    t_parse_state ps;
    logic [31:0]  left;
    logic         pad;
    logic         cur_audio;
    logic [31:0]  cur_size;
    logic [31:0]  cur_frame;
    logic [32:0]  pos;
    logic [31:0]  frame_cnt;

    // Request queues and expected results
    t_movi_req  req_q[$];
    t_movi_req  build_q[$];
    t_chunk_res chunk_exp_q[$];

    int   live_reqs  = 0;
    int   built_reqs = 0;
    int   res_count  = 0;
    int   errors     = 0;
    int   settings   = 0;
    int   kind_seen[0:7];
    int   stage_bytes = 0;
    logic noise_on   = 1'b0;

    int   burst_left = 1;
    int   gap_left   = 0;
    int   quiet_cycles = 0;
    logic [15:0] ready_pat  = 16'hFFFF;
    logic [5:0]  ready_tick = 6'd0;

    riff_movi_chunk_demux DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (req_valid),
        .o_in_ready     (req_ready),
        .i_operation    (req_op),
        .i_data_byte    (req_byte),
        .o_out_valid    (res_valid),
        .i_out_ready    (res_ready),
        .o_kind         (res_kind),
        .o_payload_byte (res_byte),
        .o_chunk_size   (res_size),
        .o_frame_num    (res_frame),
        .o_chunk_last   (res_last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic void parser_clear();
        hdr_shift = '0;
        hdr_cnt   = '0;
        ps        = PS_HEADER;
        left      = '0;
        pad       = 1'b0;
        cur_audio = 1'b0;
        cur_size  = '0;
        cur_frame = '0;
        pos       = '0;
        frame_cnt = '0;
    endfunction

    function automatic void expect_result(input logic [2:0] kind, input logic [7:0] pbyte,
                                          input logic [31:0] csize, input logic [31:0] frame,
                                          input logic last);
        t_chunk_res r;
        r.kind  = kind;
        r.pbyte = pbyte;
        r.csize = csize;
        r.frame = frame;
        r.last  = last;
        chunk_exp_q.push_back(r);
    endfunction

    function automatic void start_skip(input logic [31:0] n, input logic with_pad);
        left = n;
        pad  = with_pad;
        if (n != 0) ps = PS_SKIP;
        else ps = with_pad ? PS_PAD : PS_HEADER;
    endfunction

    // Advance the parser by one request and queue the result it causes
    function automatic void demux_step(input logic [1:0] op, input logic [7:0] db);
        logic [31:0]  tag;
        logic [31:0]  sz;
        logic [6:0]   num;
        logic         digits;
        logic         vid;
        logic         aud;
        t_parse_state was;
        if (op == rmcd_pkg::OP_NONE) return;
        if (op == rmcd_pkg::OP_REWIND) begin
            parser_clear();
            live_reqs++;
            return;
        end
        // finished: only an input-ended request answers
        if (ps == PS_DONE) begin
            if (op == rmcd_pkg::OP_ENDED) begin
                expect_result(rmcd_pkg::KIND_END, 8'h00, 32'h0, 32'h0, 1'b0);
                live_reqs++;
            end
            return;
        end
        live_reqs++;
        // end of movi is due at a header boundary
        if (ps == PS_HEADER && hdr_cnt == 0 && pos >= {1'b0, movi_lim}) begin
            ps = PS_DONE;
            expect_result(rmcd_pkg::KIND_END, 8'h00, 32'h0, 32'h0, 1'b0);
            return;
        end
        if (op == rmcd_pkg::OP_ENDED) begin
            was = ps;
            ps  = PS_DONE;
            if (was == PS_PAYLOAD)
                expect_result(rmcd_pkg::KIND_TRUNCATED, 8'h00, cur_size, cur_frame, 1'b0);
            else
                expect_result(rmcd_pkg::KIND_END, 8'h00, 32'h0, 32'h0, 1'b0);
            return;
        end
        if (pos != rmcd_pkg::POS_MAX) pos++;
        case (ps)
            PS_HEADER: begin
                if (hdr_cnt < 3'd7) begin
                    hdr_shift[8 * hdr_cnt +: 8] = db;
                    hdr_cnt++;
                end else begin
                    tag = hdr_shift[31:0];
                    sz  = {db, hdr_shift[55:32]};
                    hdr_shift = '0;
                    hdr_cnt   = '0;
                    digits = tag[7:0] >= rmcd_pkg::CHR_0 && tag[7:0] <= rmcd_pkg::CHR_9 &&
                             tag[15:8] >= rmcd_pkg::CHR_0 && tag[15:8] <= rmcd_pkg::CHR_9;
                    num = 7'((tag[7:0] - rmcd_pkg::CHR_0) * rmcd_pkg::DEC_BASE +
                             (tag[15:8] - rmcd_pkg::CHR_0));
                    vid = digits && tag[23:16] == rmcd_pkg::CHR_D &&
                          (tag[31:24] == rmcd_pkg::CHR_C || tag[31:24] == rmcd_pkg::CHR_B) &&
                          vid_en && num == vid_num;
                    aud = digits && tag[23:16] == rmcd_pkg::CHR_W &&
                          tag[31:24] == rmcd_pkg::CHR_B && aud_en && num == aud_num;
                    if (tag == rmcd_pkg::TAG_LIST) begin
                        start_skip(32'd4, 1'b0);
                    end else if (tag == rmcd_pkg::TAG_JUNK || !(vid || aud)) begin
                        start_skip(sz, sz[0]);
                    end else begin
                        cur_audio = aud;
                        cur_size  = sz;
                        cur_frame = vid ? frame_cnt : 32'h0;
                        if (vid) frame_cnt++;
                        if (sz == 0) begin
                            expect_result(aud ? rmcd_pkg::KIND_EMPTY_AUDIO
                                              : rmcd_pkg::KIND_EMPTY_VIDEO, 8'h00,
                                          32'h0, cur_frame, 1'b1);
                        end else begin
                            left = sz;
                            pad  = sz[0];
                            ps   = PS_PAYLOAD;
                        end
                    end
                end
            end
            PS_SKIP: begin
                left--;
                if (left == 0) ps = pad ? PS_PAD : PS_HEADER;
            end
            PS_PAD: begin
                pad = 1'b0;
                ps  = PS_HEADER;
            end
            PS_PAYLOAD: begin
                left--;
                if (left == 0) ps = pad ? PS_PAD : PS_HEADER;
                expect_result(cur_audio ? rmcd_pkg::KIND_AUDIO : rmcd_pkg::KIND_VIDEO, db,
                              cur_size, cur_frame, left == 0);
            end
            default: ps = PS_DONE;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Stream building
    // ---------------------------------------------------------------
    function automatic logic [31:0] fourcc(input logic [7:0] c0, input logic [7:0] c1,
                                           input logic [7:0] c2, input logic [7:0] c3);
        return {c3, c2, c1, c0};
    endfunction

    function automatic logic [31:0] stream_tag(input int num, input logic [7:0] c2,
                                               input logic [7:0] c3);
        return fourcc(8'(rmcd_pkg::CHR_0 + num / rmcd_pkg::DEC_BASE),
                      8'(rmcd_pkg::CHR_0 + num % rmcd_pkg::DEC_BASE), c2, c3);
    endfunction

    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 32'd0;
        if (r < 70) return $urandom_range(1, 8);
        if (r < 93) return $urandom_range(9, 40);
        return $urandom_range(41, 160);
    endfunction

    // Append one request, with an occasional no-op slipped in ahead of it
    function automatic void put(input logic [1:0] op, input logic [7:0] db);
        if (noise_on && $urandom_range(0, 99) < 3) begin
            build_q.push_back('{op: rmcd_pkg::OP_NONE, data: 8'($urandom())});
            built_reqs++;
        end
        build_q.push_back('{op: op, data: db});
        built_reqs++;
        if (op == rmcd_pkg::OP_DATA) stage_bytes++;
        if (op == rmcd_pkg::OP_REWIND) stage_bytes = 0;
    endfunction

    function automatic void put_header(input logic [31:0] tag, input logic [31:0] csize);
        for (int k = 0; k < 4; k++) put(rmcd_pkg::OP_DATA, tag[8 * k +: 8]);
        for (int k = 0; k < 4; k++) put(rmcd_pkg::OP_DATA, csize[8 * k +: 8]);
    endfunction

    function automatic void put_chunk(input logic [31:0] tag, input logic [31:0] csize);
        put_header(tag, csize);
        for (int k = 0; k < csize; k++) put(rmcd_pkg::OP_DATA, 8'($urandom()));
        if (csize[0]) put(rmcd_pkg::OP_DATA, 8'($urandom()));
    endfunction

    // ---------------------------------------------------------------
    // Sequencing helpers
    // ---------------------------------------------------------------
    task automatic wait_drained(input int settle);
        do begin
            @(negedge clk);
        end while (req_q.size() != 0 || req_valid || chunk_exp_q.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        case (idx)
            rmcd_pkg::CFG_MOVI_SIZE:    movi_lim = val;
            rmcd_pkg::CFG_VIDEO_STREAM: vid_num  = val[6:0];
            rmcd_pkg::CFG_AUDIO_STREAM: aud_num  = val[6:0];
            rmcd_pkg::CFG_VIDEO_ENABLE: vid_en   = val[0];
            rmcd_pkg::CFG_AUDIO_ENABLE: aud_en   = val[0];
            default: ;
        endcase
    endtask

    // Wait for idle, program all registers, then release the staged requests
    task automatic run_phase(input logic [31:0] movi, input logic [6:0] vn,
                             input logic [6:0] an, input logic ve, input logic ae);
        wait_drained(SETTLE_CYCLES);
        write_reg(rmcd_pkg::CFG_MOVI_SIZE, movi);
        write_reg(rmcd_pkg::CFG_VIDEO_STREAM, 32'(vn));
        write_reg(rmcd_pkg::CFG_AUDIO_STREAM, 32'(an));
        write_reg(rmcd_pkg::CFG_VIDEO_ENABLE, 32'(ve));
        write_reg(rmcd_pkg::CFG_AUDIO_ENABLE, 32'(ae));
        cfg_valid <= 1'b0;
        settings++;
        foreach (build_q[i]) req_q.push_back(build_q[i]);
        build_q.delete();
    endtask

    // ---------------------------------------------------------------
    // Request driver: bursts with random gaps
    // ---------------------------------------------------------------
    always @(posedge clk) begin : req_driver
        t_movi_req nxt;
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && req_ready) demux_step(req_op, req_byte);
            if (!req_valid || req_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    req_valid <= 1'b0;
                end else if (req_q.size() != 0) begin
                    nxt = req_q.pop_front();
                    req_valid <= 1'b1;
                    req_op    <= nxt.op;
                    req_byte  <= nxt.data;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 32);
                        gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor and receiver stall pattern
    // ---------------------------------------------------------------
    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: mismatch in %s, expected %0h, actual %0h", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin : res_monitor
        t_chunk_res e;
        if (rst_n && res_valid && res_ready) begin
            res_count++;
            kind_seen[res_kind]++;
            if (chunk_exp_q.size() == 0) begin
                $display("%0t: mismatch, expected no result, actual kind %0d byte %0h",
                         $time, res_kind, res_byte);
                errors++;
            end else begin
                e = chunk_exp_q.pop_front();
                check_field("kind", 32'(e.kind), 32'(res_kind));
                check_field("payload_byte", 32'(e.pbyte), 32'(res_byte));
                check_field("chunk_size", e.csize, res_size);
                check_field("frame_num", e.frame, res_frame);
                check_field("chunk_last", 32'(e.last), 32'(res_last));
            end
        end
        // new stall pattern each time the tick counter wraps
        ready_tick = ready_tick + 1'b1;
        if (ready_tick == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pat = 16'hFFFF;
                1: ready_pat = 16'($urandom());
                2: ready_pat = 16'h0001;
                default: ready_pat = 16'hAAAA;
            endcase
        end
        res_ready <= ready_pat[ready_tick[3:0]];
    end

    // Watchdog: no handshake of any kind for too long
    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (res_valid && res_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin
        logic [6:0]  vn;
        logic [6:0]  an;
        logic        ve;
        logic        ae;
        logic [31:0] sz;
        logic [31:0] movi;
        logic [31:0] big;
        logic [31:0] tag;
        int          pick;
        int          n_chunks;
        int          k;
        int          phase_no;

        foreach (kind_seen[i]) kind_seen[i] = 0;
        parser_clear();
        phase_no = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: movi size 0 ends at once, then finished behavior
        put(rmcd_pkg::OP_DATA, 8'h00);
        put(rmcd_pkg::OP_DATA, 8'hFF);
        put(rmcd_pkg::OP_ENDED, 8'hA5);
        put(rmcd_pkg::OP_NONE, 8'h5A);
        put(rmcd_pkg::OP_REWIND, 8'hFF);
        foreach (build_q[i]) req_q.push_back(build_q[i]);
        build_q.delete();

        // Directed walk: empty video, odd audio with pad, even video,
        // empty audio, truncation mid-payload, finished block
        put_chunk(stream_tag(0, rmcd_pkg::CHR_D, rmcd_pkg::CHR_C), 32'd0);
        put_header(stream_tag(99, rmcd_pkg::CHR_W, rmcd_pkg::CHR_B), 32'd1);
        put(rmcd_pkg::OP_DATA, 8'hFF);
        put(rmcd_pkg::OP_DATA, 8'h00);
        put_header(stream_tag(0, rmcd_pkg::CHR_D, rmcd_pkg::CHR_B), 32'd2);
        put(rmcd_pkg::OP_DATA, 8'h00);
        put(rmcd_pkg::OP_DATA, 8'h80);
        put_chunk(stream_tag(99, rmcd_pkg::CHR_W, rmcd_pkg::CHR_B), 32'd0);
        put_header(stream_tag(0, rmcd_pkg::CHR_D, rmcd_pkg::CHR_C), 32'd3);
        put(rmcd_pkg::OP_DATA, 8'h7F);
        put(rmcd_pkg::OP_ENDED, 8'h00);
        put(rmcd_pkg::OP_DATA, 8'h55);
        put(rmcd_pkg::OP_ENDED, 8'hFF);
        run_phase(32'hFFFF_FFFF, 7'd0, 7'd99, 1'b1, 1'b1);

        // Random well-formed streams with noise and broken endings
        while (built_reqs < REQ_TARGET) begin
            phase_no++;
            vn = (phase_no == 1) ? 7'd0 : (phase_no == 2) ? 7'd99 : 7'($urandom_range(0, 99));
            if (phase_no == 1) an = 7'd99;
            else if (phase_no == 2) an = 7'd0;
            else an = ($urandom_range(0, 3) == 0) ? vn : 7'($urandom_range(0, 99));
            ve = $urandom_range(0, 7) != 0;
            ae = $urandom_range(0, 7) != 0;
            noise_on = 1'b1;
            put(rmcd_pkg::OP_REWIND, 8'($urandom()));

            n_chunks = $urandom_range(3, 12);
            for (int c = 0; c < n_chunks; c++) begin
                pick = $urandom_range(0, 99);
                sz   = pick_size();
                if (pick < 33) begin
                    put_chunk(stream_tag(vn, rmcd_pkg::CHR_D,
                                         $urandom_range(0, 1) ? rmcd_pkg::CHR_C
                                                              : rmcd_pkg::CHR_B), sz);
                end else if (pick < 60) begin
                    put_chunk(stream_tag(an, rmcd_pkg::CHR_W, rmcd_pkg::CHR_B), sz);
                end else if (pick < 68) begin
                    // some other stream
                    put_chunk(stream_tag($urandom_range(0, 99),
                                         $urandom_range(0, 1) ? rmcd_pkg::CHR_D
                                                              : rmcd_pkg::CHR_W,
                                         rmcd_pkg::CHR_B), sz);
                end else if (pick < 75) begin
                    put_chunk(rmcd_pkg::TAG_JUNK, sz);
                end else if (pick < 82) begin
                    // list header: only its type is consumed
                    put_header(rmcd_pkg::TAG_LIST, $urandom());
                    repeat (4) put(rmcd_pkg::OP_DATA, 8'($urandom()));
                end else if (pick < 97) begin
                    // tags that just miss a stream pattern
                    case ($urandom_range(0, 5))
                        0: tag = fourcc(8'h2F, rmcd_pkg::CHR_0, rmcd_pkg::CHR_D,
                                        rmcd_pkg::CHR_C);
                        1: tag = fourcc(rmcd_pkg::CHR_9, 8'h3A, rmcd_pkg::CHR_W,
                                        rmcd_pkg::CHR_B);
                        2: tag = stream_tag(vn, rmcd_pkg::CHR_D, rmcd_pkg::CHR_W);
                        3: tag = stream_tag(an, rmcd_pkg::CHR_W, rmcd_pkg::CHR_C);
                        4: tag = stream_tag(vn, 8'($urandom()), 8'($urandom()));
                        default: tag = $urandom();
                    endcase
                    put_chunk(tag, sz);
                end else begin
                    put(rmcd_pkg::OP_REWIND, 8'($urandom()));
                end
            end

            // how the stream stops
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                put(rmcd_pkg::OP_ENDED, 8'($urandom()));
            end else if (pick < 65) begin
                // video or audio stream chunk cut inside its payload, size up to full width
                k   = $urandom_range(0, 6);
                big = $urandom_range(0, 1) ? $urandom() : 32'(k + 1 + $urandom_range(0, 30));
                if (big <= k) big = k + 1;
                put_header($urandom_range(0, 1)
                               ? stream_tag(vn, rmcd_pkg::CHR_D, rmcd_pkg::CHR_C)
                               : stream_tag(an, rmcd_pkg::CHR_W, rmcd_pkg::CHR_B), big);
                repeat (k) put(rmcd_pkg::OP_DATA, 8'($urandom()));
                put(rmcd_pkg::OP_ENDED, 8'($urandom()));
            end else if (pick < 80) begin
                // inside a partial header
                repeat ($urandom_range(1, 7)) put(rmcd_pkg::OP_DATA, 8'($urandom()));
                put(rmcd_pkg::OP_ENDED, 8'($urandom()));
            end else if (pick < 90) begin
                // inside a skip
                put_header(rmcd_pkg::TAG_JUNK, $urandom());
                repeat ($urandom_range(0, 5)) put(rmcd_pkg::OP_DATA, 8'($urandom()));
                put(rmcd_pkg::OP_ENDED, 8'($urandom()));
            end else begin
                // on the pad byte of an odd chunk
                sz = 32'(2 * $urandom_range(0, 4) + 1);
                put_header(stream_tag(an, rmcd_pkg::CHR_W, rmcd_pkg::CHR_B), sz);
                repeat (sz) put(rmcd_pkg::OP_DATA, 8'($urandom()));
                put(rmcd_pkg::OP_ENDED, 8'($urandom()));
            end
            if ($urandom_range(0, 1)) begin
                repeat ($urandom_range(1, 4)) put(rmcd_pkg::OP_DATA, 8'($urandom()));
                put(rmcd_pkg::OP_ENDED, 8'($urandom()));
            end

            // movi size: exact, short, huge or tiny
            pick = $urandom_range(0, 99);
            if (pick < 45) movi = stage_bytes;
            else if (pick < 65) movi = $urandom_range(0, stage_bytes);
            else if (pick < 80) movi = 32'hFFFF_FFFF;
            else if (pick < 90) movi = $urandom();
            else movi = $urandom_range(0, 15);

            run_phase(movi, vn, an, ve, ae);
        end

        wait_drained(END_CYCLES);
        $display("Run covered %0d parsed requests and %0d results over %0d register settings",
                 live_reqs, res_count, settings);
        $display("Results: video %0d, audio %0d, empty %0d/%0d, end %0d, truncated %0d",
                 kind_seen[rmcd_pkg::KIND_VIDEO], kind_seen[rmcd_pkg::KIND_AUDIO],
                 kind_seen[rmcd_pkg::KIND_EMPTY_VIDEO], kind_seen[rmcd_pkg::KIND_EMPTY_AUDIO],
                 kind_seen[rmcd_pkg::KIND_END], kind_seen[rmcd_pkg::KIND_TRUNCATED]);
        if (errors == 0 && chunk_exp_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
